// ===== sv/sha1_pkg.sv =====
// shared types and constants for the sha-1 hash engine
`timescale 1ns / 1ps

package sha1_pkg;

   localparam int unsigned NUM_WORDS = 5;

   typedef logic [31:0] word_type;

   localparam word_type INIT_H0 = 32'h67452301;
   localparam word_type INIT_H1 = 32'hEFCDAB89;
   localparam word_type INIT_H2 = 32'h98BADCFE;
   localparam word_type INIT_H3 = 32'h10325476;
   localparam word_type INIT_H4 = 32'hC3D2E1F0;

   localparam word_type K_CH   = 32'h5A827999;
   localparam word_type K_PAR1 = 32'h6ED9EBA1;
   localparam word_type K_MAJ  = 32'h8F1BBCDC;
   localparam word_type K_PAR2 = 32'hCA62C1D6;

   localparam logic [7:0] PAD_BYTE = 8'h80;

   localparam logic [2:0] LAST_WORD_IDX = 3'd4;

   // source of the byte shifted into the message window
   typedef enum logic [1:0] {
      BYTE_IN,
      BYTE_PAD,
      BYTE_ZERO,
      BYTE_LEN
   } byte_sel_type;

   // round function group, 20 rounds each
   typedef enum logic [1:0] {
      PHASE_CH,
      PHASE_PAR1,
      PHASE_MAJ,
      PHASE_PAR2
   } phase_type;

   typedef struct packed {
      logic         shift_byte;
      logic         count_up;
      byte_sel_type byte_sel;
      logic [2:0]   len_idx;
      logic         load_vars;
      logic         round_step;
      phase_type    phase;
      logic         chain_add;
      logic         clear_state;
      logic [2:0]   out_idx;
   } cmd_type;

   typedef struct packed {
      logic [5:0] fill;
   } status_type;

   function automatic word_type round_const(input phase_type phase);
      word_type k;
      case (phase)
         PHASE_CH:   k = K_CH;
         PHASE_PAR1: k = K_PAR1;
         PHASE_MAJ:  k = K_MAJ;
         PHASE_PAR2: k = K_PAR2;
         default:    k = K_CH;
      endcase
      return k;
   endfunction

endpackage

// ===== sv/sha1_hash_engine.sv =====
// sha-1 hash engine top level: controller plus datapath on stream ports
// a message byte is accepted in the idle state; the 64th byte of a block
// starts 80 rounds on the single round unit plus the chaining-word update
// end of message: padding bytes up to the block end, one or two
// compressions, then five digest transactions, one per ready cycle
// synchronous active-high reset loads the initial hash words and a zero count
`timescale 1ns / 1ps

module sha1_hash_engine (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic        req_tuser,   // [0] has_byte
   input  logic        req_tlast,   // end_of_message
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [31:0] digest_word
   output logic [2:0]  rsp_tuser,   // [2:0] word_index
   output logic        rsp_tlast    // last_word
);
   import sha1_pkg::*;

   cmd_type    cmd;
   status_type status;

   sha1_ctrl u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .req_tvalid   (req_tvalid),
      .req_tready   (req_tready),
      .req_has_byte (req_tuser),
      .req_end      (req_tlast),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_tlast    (rsp_tlast),
      .rsp_index    (rsp_tuser),
      .status       (status),
      .cmd          (cmd)
   );

   sha1_dp u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .req_byte    (req_tdata),
      .status      (status),
      .digest_word (rsp_tdata)
   );

endmodule

// ===== sv/sha1_dp.sv =====
// sha-1 datapath: message window, round variables, chaining words, byte count
`timescale 1ns / 1ps

module sha1_dp (
   input  logic                clock,
   input  logic                reset,
   input  sha1_pkg::cmd_type   cmd,
   input  logic [7:0]          req_byte,
   output sha1_pkg::status_type status,
   output sha1_pkg::word_type  digest_word
);
   import sha1_pkg::*;

   function automatic word_type rotl(input word_type x, input int unsigned n);
      return (x << n) | (x >> (32 - n));
   endfunction

   // 16-word window, oldest word in the top bits
   logic [511:0] msg_ff, msg_in;
   word_type     a_ff, b_ff, c_ff, d_ff, e_ff;
   word_type     a_in, b_in, c_in, d_in, e_in;
   word_type     chain_ff [NUM_WORDS];
   word_type     chain_in [NUM_WORDS];
   logic [60:0]  count_ff, count_in;

   logic [63:0]  len_bits;
   logic [7:0]   shift_byte;
   word_type     w_cur, w_next, f_val, t_val;

   assign len_bits = {count_ff, 3'b000};
   assign w_cur    = msg_ff[511:480];
   assign w_next   = rotl(msg_ff[95:64] ^ msg_ff[255:224] ^ msg_ff[447:416] ^ msg_ff[511:480],
                          1);

   always_comb begin
      case (cmd.byte_sel)
         BYTE_IN:   shift_byte = req_byte;
         BYTE_PAD:  shift_byte = PAD_BYTE;
         BYTE_LEN:  shift_byte = len_bits[{~cmd.len_idx, 3'b000} +: 8];
         default:   shift_byte = 8'h00;
      endcase
   end

   always_comb begin
      case (cmd.phase)
         PHASE_CH:  f_val = (b_ff & c_ff) | (~b_ff & d_ff);
         PHASE_MAJ: f_val = (b_ff & c_ff) | (b_ff & d_ff) | (c_ff & d_ff);
         default:   f_val = b_ff ^ c_ff ^ d_ff;
      endcase
   end

   assign t_val = rotl(a_ff, 5) + f_val + e_ff + round_const(cmd.phase) + w_cur;

   always_comb begin
      msg_in = msg_ff;
      if (cmd.shift_byte) begin
         msg_in = {msg_ff[503:0], shift_byte};
      end else if (cmd.round_step) begin
         msg_in = {msg_ff[479:0], w_next};
      end
   end

   always_comb begin
      a_in = a_ff;
      b_in = b_ff;
      c_in = c_ff;
      d_in = d_ff;
      e_in = e_ff;
      if (cmd.load_vars) begin
         a_in = chain_ff[0];
         b_in = chain_ff[1];
         c_in = chain_ff[2];
         d_in = chain_ff[3];
         e_in = chain_ff[4];
      end else if (cmd.round_step) begin
         a_in = t_val;
         b_in = a_ff;
         c_in = rotl(b_ff, 30);
         d_in = c_ff;
         e_in = d_ff;
      end
   end

   always_comb begin
      chain_in = chain_ff;
      count_in = count_ff;
      if (cmd.clear_state) begin
         chain_in[0] = INIT_H0;
         chain_in[1] = INIT_H1;
         chain_in[2] = INIT_H2;
         chain_in[3] = INIT_H3;
         chain_in[4] = INIT_H4;
         count_in    = '0;
      end else begin
         if (cmd.chain_add) begin
            chain_in[0] = chain_ff[0] + a_ff;
            chain_in[1] = chain_ff[1] + b_ff;
            chain_in[2] = chain_ff[2] + c_ff;
            chain_in[3] = chain_ff[3] + d_ff;
            chain_in[4] = chain_ff[4] + e_ff;
         end
         if (cmd.count_up) begin
            count_in = count_ff + 61'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      msg_ff <= msg_in;
      a_ff   <= a_in;
      b_ff   <= b_in;
      c_ff   <= c_in;
      d_ff   <= d_in;
      e_ff   <= e_in;
      if (reset) begin
         chain_ff[0] <= INIT_H0;
         chain_ff[1] <= INIT_H1;
         chain_ff[2] <= INIT_H2;
         chain_ff[3] <= INIT_H3;
         chain_ff[4] <= INIT_H4;
         count_ff    <= '0;
      end else begin
         chain_ff <= chain_in;
         count_ff <= count_in;
      end
   end

   always_comb begin
      case (cmd.out_idx)
         3'd0:    digest_word = chain_ff[0];
         3'd1:    digest_word = chain_ff[1];
         3'd2:    digest_word = chain_ff[2];
         3'd3:    digest_word = chain_ff[3];
         3'd4:    digest_word = chain_ff[4];
         default: digest_word = chain_ff[0];
      endcase
   end

   assign status.fill = count_ff[5:0];

endmodule

// ===== sv/sha1_ctrl.sv =====
// sha-1 controller: byte intake, padding sequence, round count, digest output
`timescale 1ns / 1ps

module sha1_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic                 req_has_byte,
   input  logic                 req_end,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic                 rsp_tlast,
   output logic [2:0]           rsp_index,
   input  sha1_pkg::status_type status,
   output sha1_pkg::cmd_type    cmd
);
   import sha1_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE,
      S_ROUND,
      S_CHAIN,
      S_PAD,
      S_OUT
   } state_type;

   localparam logic [6:0] ROUND_LAST = 7'd79;
   localparam logic [5:0] POS_LAST   = 6'd63;
   localparam logic [5:0] POS_LEN    = 6'd56;

   state_type  state_ff, state_in;
   logic [6:0] round_ff, round_in;
   logic [5:0] pad_pos_ff, pad_pos_in;
   logic       first_ff, first_in;
   logic       len_ff, len_in;
   logic       end_pend_ff, end_pend_in;
   logic       pad_mode_ff, pad_mode_in;
   logic [2:0] out_idx_ff, out_idx_in;

   logic [5:0] pos;

   // first padding step starts where the message bytes stopped
   assign pos = first_ff ? status.fill : pad_pos_ff;

   always_comb begin
      state_in    = state_ff;
      round_in    = round_ff;
      pad_pos_in  = pad_pos_ff;
      first_in    = first_ff;
      len_in      = len_ff;
      end_pend_in = end_pend_ff;
      pad_mode_in = pad_mode_ff;
      out_idx_in  = out_idx_ff;
      cmd         = '0;
      cmd.byte_sel = BYTE_ZERO;
      cmd.phase    = PHASE_CH;
      cmd.out_idx  = out_idx_ff;
      req_tready  = 1'b0;
      rsp_tvalid  = 1'b0;

      if (round_ff < 7'd20) begin
         cmd.phase = PHASE_CH;
      end else if (round_ff < 7'd40) begin
         cmd.phase = PHASE_PAR1;
      end else if (round_ff < 7'd60) begin
         cmd.phase = PHASE_MAJ;
      end else begin
         cmd.phase = PHASE_PAR2;
      end

      case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               if (req_has_byte) begin
                  cmd.shift_byte = 1'b1;
                  cmd.count_up   = 1'b1;
                  cmd.byte_sel   = BYTE_IN;
               end
               if (req_has_byte && status.fill == POS_LAST) begin
                  cmd.load_vars = 1'b1;
                  round_in      = '0;
                  end_pend_in   = req_end;
                  state_in      = S_ROUND;
               end else if (req_end) begin
                  first_in    = 1'b1;
                  len_in      = 1'b0;
                  pad_mode_in = 1'b1;
                  state_in    = S_PAD;
               end
            end
         end
         S_PAD: begin
            cmd.shift_byte = 1'b1;
            cmd.len_idx    = pos[2:0];
            if (first_ff) begin
               cmd.byte_sel = BYTE_PAD;
            end else if (pos == POS_LEN || len_ff) begin
               cmd.byte_sel = BYTE_LEN;
            end else begin
               cmd.byte_sel = BYTE_ZERO;
            end
            pad_pos_in = pos + 6'd1;
            first_in   = 1'b0;
            if (!first_ff && pos == POS_LEN) begin
               len_in = 1'b1;
            end
            if (pos == POS_LAST) begin
               cmd.load_vars = 1'b1;
               round_in      = '0;
               state_in      = S_ROUND;
            end
         end
         S_ROUND: begin
            cmd.round_step = 1'b1;
            round_in       = round_ff + 7'd1;
            if (round_ff == ROUND_LAST) begin
               state_in = S_CHAIN;
            end
         end
         S_CHAIN: begin
            cmd.chain_add = 1'b1;
            if (pad_mode_ff) begin
               if (len_ff) begin
                  out_idx_in = '0;
                  state_in   = S_OUT;
               end else begin
                  state_in = S_PAD;
               end
            end else if (end_pend_ff) begin
               end_pend_in = 1'b0;
               first_in    = 1'b1;
               len_in      = 1'b0;
               pad_mode_in = 1'b1;
               state_in    = S_PAD;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_OUT: begin
            rsp_tvalid = 1'b1;
            if (rsp_tready) begin
               if (out_idx_ff == LAST_WORD_IDX) begin
                  cmd.clear_state = 1'b1;
                  pad_mode_in     = 1'b0;
                  end_pend_in     = 1'b0;
                  len_in          = 1'b0;
                  first_in        = 1'b0;
                  out_idx_in      = '0;
                  state_in        = S_IDLE;
               end else begin
                  out_idx_in = out_idx_ff + 3'd1;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign rsp_tlast = (out_idx_ff == LAST_WORD_IDX);
   assign rsp_index = out_idx_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         round_ff    <= '0;
         pad_pos_ff  <= '0;
         first_ff    <= 1'b0;
         len_ff      <= 1'b0;
         end_pend_ff <= 1'b0;
         pad_mode_ff <= 1'b0;
         out_idx_ff  <= '0;
      end else begin
         state_ff    <= state_in;
         round_ff    <= round_in;
         pad_pos_ff  <= pad_pos_in;
         first_ff    <= first_in;
         len_ff      <= len_in;
         end_pend_ff <= end_pend_in;
         pad_mode_ff <= pad_mode_in;
         out_idx_ff  <= out_idx_in;
      end
   end

endmodule

// ===== sim/testbench.sv =====
// self-checking testbench for the byte-serial sha-1 hash engine
`timescale 1ns / 1ps

module testbench;
   import sha1_pkg::*;

   localparam int QUIET_LIMIT = 4000;
   localparam int SETTLE_CYCLES = 300;
   localparam int RANDOM_ITEMS = 250;

   typedef struct packed {
      word_type   digest_word;
      logic [2:0] word_index;
      logic       last_word;
   } digest_item_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;   // [7:0] data_byte
   logic        req_tuser;   // [0] has_byte
   logic        req_tlast;   // end_of_message
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;   // [31:0] digest_word
   logic [2:0]  rsp_tuser;   // [2:0] word_index
   logic        rsp_tlast;   // last_word

   // expected digest state, mirrors the engine
   word_type    hash_chain[5];
   logic [7:0]  msg_block[64];
   logic [60:0] msg_len;

   digest_item_type expected_digest_words[$];

   int  error_count = 0;
   int  items_sent = 0;
   int  quiet_cycles = 0;
   int  ready_hold = 0;
   int  ready_stall;
   bit  send_burst = 1'b0;
   bit  ready_burst = 1'b0;

   sha1_hash_engine dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic void clear_hash_state();
      int i;
      hash_chain[0] = INIT_H0;
      hash_chain[1] = INIT_H1;
      hash_chain[2] = INIT_H2;
      hash_chain[3] = INIT_H3;
      hash_chain[4] = INIT_H4;
      for (i = 0; i < 64; i++)
         msg_block[i] = 8'h00;
      msg_len = '0;
   endfunction

   // 80 rounds over msg_block, folded into hash_chain
   function automatic void compress_msg_block();
      word_type w[16];
      word_type a, b, c, d, e, f, k, t;
      int r;
      for (r = 0; r < 16; r++)
         w[r] = {msg_block[4*r], msg_block[4*r+1], msg_block[4*r+2], msg_block[4*r+3]};
      a = hash_chain[0];
      b = hash_chain[1];
      c = hash_chain[2];
      d = hash_chain[3];
      e = hash_chain[4];
      for (r = 0; r < 80; r++) begin
         if (r >= 16) begin
            t = w[(r + 13) & 15] ^ w[(r + 8) & 15] ^ w[(r + 2) & 15] ^ w[r & 15];
            w[r & 15] = {t[30:0], t[31]};
         end
         if (r < 20) begin
            f = (b & c) | (~b & d);
            k = K_CH;
         end else if (r < 40) begin
            f = b ^ c ^ d;
            k = K_PAR1;
         end else if (r < 60) begin
            f = (b & c) | (b & d) | (c & d);
            k = K_MAJ;
         end else begin
            f = b ^ c ^ d;
            k = K_PAR2;
         end
         t = {a[26:0], a[31:27]} + f + e + k + w[r & 15];
         e = d;
         d = c;
         c = {b[1:0], b[31:2]};
         b = a;
         a = t;
      end
      hash_chain[0] += a;
      hash_chain[1] += b;
      hash_chain[2] += c;
      hash_chain[3] += d;
      hash_chain[4] += e;
   endfunction

   // take one accepted transaction, queue the five digest words on message end
   function automatic void absorb_message_item(input logic [7:0] data_byte,
                                               input logic has_byte,
                                               input logic end_of_message);
      int pos;
      int i;
      logic [63:0] bit_len;
      digest_item_type word_out;
      if (has_byte) begin
         pos = msg_len[5:0];
         msg_block[pos] = data_byte;
         msg_len = msg_len + 1'b1;
         if (pos == 63)
            compress_msg_block();
      end
      if (!end_of_message)
         return;
      pos = msg_len[5:0];
      msg_block[pos] = PAD_BYTE;
      pos = pos + 1;
      // no room for the length field: pad out and spend an extra block
      if (pos > 56) begin
         while (pos < 64) begin
            msg_block[pos] = 8'h00;
            pos = pos + 1;
         end
         compress_msg_block();
         pos = 0;
      end
      while (pos < 56) begin
         msg_block[pos] = 8'h00;
         pos = pos + 1;
      end
      bit_len = {msg_len, 3'b000};
      for (i = 0; i < 8; i++)
         msg_block[56 + i] = bit_len[63 - 8*i -: 8];
      compress_msg_block();
      for (i = 0; i < NUM_WORDS; i++) begin
         word_out.digest_word = hash_chain[i];
         word_out.word_index = i[2:0];
         word_out.last_word = (i[2:0] == LAST_WORD_IDX);
         expected_digest_words = {expected_digest_words, word_out};
      end
      clear_hash_state();
   endfunction

   task automatic send_item(input logic [7:0] data_byte, input logic has_byte,
                            input logic end_of_message);
      int gap;
      gap = send_burst ? 0 : $urandom_range(0, 5);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= data_byte;
      req_tuser <= has_byte;
      req_tlast <= end_of_message;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      absorb_message_item(data_byte, has_byte, end_of_message);
      items_sent++;
      if ($urandom_range(0, 15) == 0)
         send_burst = ~send_burst;
   endtask

   task automatic wait_for_digests();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (expected_digest_words.size() != 0) @(posedge clock);
   endtask

   task automatic test_idle_and_empty();
      send_item(8'hA5, 1'b0, 1'b0);
      send_item(8'hFF, 1'b0, 1'b1);
   endtask

   task automatic test_end_with_byte();
      send_item(8'h61, 1'b1, 1'b0);
      send_item(8'h62, 1'b1, 1'b0);
      send_item(8'h63, 1'b1, 1'b1);
   endtask

   task automatic test_end_after_bytes();
      send_item(8'h00, 1'b1, 1'b0);
      send_item(8'hFF, 1'b1, 1'b0);
      send_item(8'h3C, 1'b0, 1'b0);
      send_item(8'h00, 1'b0, 1'b1);
   endtask

   task automatic test_back_to_back();
      send_item(8'h80, 1'b1, 1'b1);
      send_item(8'h7F, 1'b1, 1'b1);
   endtask

   task automatic test_sender_pause();
      send_item(8'hC3, 1'b1, 1'b0);
      send_item(8'h5A, 1'b1, 1'b1);
      wait_for_digests();
   endtask

   task automatic test_random_messages();
      int msg_bytes;
      int i;
      logic end_with_byte;
      while (items_sent < RANDOM_ITEMS) begin
         case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: msg_bytes = $urandom_range(0, 20);
            5, 6, 7: begin
               // lengths around the padding and block edges
               case ($urandom_range(0, 4))
                  0: msg_bytes = 55;
                  1: msg_bytes = 56;
                  2: msg_bytes = 57;
                  3: msg_bytes = 63;
                  default: msg_bytes = 64;
               endcase
               msg_bytes = msg_bytes + 64 * $urandom_range(0, 1);
            end
            default: msg_bytes = $urandom_range(0, 140);
         endcase
         // keep the last message inside the item budget
         if (msg_bytes > RANDOM_ITEMS - items_sent)
            msg_bytes = RANDOM_ITEMS - items_sent;
         end_with_byte = (msg_bytes > 0) && ($urandom_range(0, 1) == 1);
         for (i = 0; i < msg_bytes; i++) begin
            if ($urandom_range(0, 9) == 0)
               send_item(8'($urandom), 1'b0, 1'b0);
            send_item(8'($urandom), 1'b1, end_with_byte && (i == msg_bytes - 1));
         end
         if (!end_with_byte)
            send_item(8'($urandom), 1'b0, 1'b1);
         if ($urandom_range(0, 5) == 0)
            wait_for_digests();
      end
   endtask

   // result side: random back-pressure, with stall-free stretches
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         ready_hold <= 0;
      end else if (ready_hold > 0) begin
         ready_hold <= ready_hold - 1;
         rsp_tready <= (ready_hold == 1);
      end else if (rsp_tvalid && rsp_tready) begin
         ready_stall = ready_burst ? 0 : $urandom_range(0, 5);
         ready_hold <= ready_stall;
         rsp_tready <= (ready_stall == 0);
         if ($urandom_range(0, 11) == 0)
            ready_burst <= ~ready_burst;
      end else begin
         rsp_tready <= ready_burst || ($urandom_range(0, 3) != 0);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_digest_words.size() == 0) begin
            $error("unexpected digest transaction: word %h index %0d last %b",
                   rsp_tdata, rsp_tuser, rsp_tlast);
            error_count++;
         end else begin
            if (rsp_tdata !== expected_digest_words[0].digest_word) begin
               $error("digest_word: expected %h, got %h",
                      expected_digest_words[0].digest_word, rsp_tdata);
               error_count++;
            end
            if (rsp_tuser !== expected_digest_words[0].word_index) begin
               $error("word_index: expected %0d, got %0d",
                      expected_digest_words[0].word_index, rsp_tuser);
               error_count++;
            end
            if (rsp_tlast !== expected_digest_words[0].last_word) begin
               $error("last_word: expected %b, got %b",
                      expected_digest_words[0].last_word, rsp_tlast);
               error_count++;
            end
            void'(expected_digest_words.pop_front());
         end
      end
   end

   // watchdog on cycles with no transaction on either side
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("timeout: no transaction for %0d cycles", QUIET_LIMIT);
            $display("Testbench completed WITH ERRORS");
            $finish;
         end
      end
   end

   initial begin
      reset <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata <= 8'h00;
      req_tuser <= 1'b0;
      req_tlast <= 1'b0;
      clear_hash_state();
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      test_idle_and_empty();
      test_end_with_byte();
      test_end_after_bytes();
      test_back_to_back();
      test_sender_pause();
      test_random_messages();

      req_tvalid <= 1'b0;
      while (expected_digest_words.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
